[design/fba_pkg.sv]
package fba_pkg;

	// Geometry defaults and per-tick limits
	localparam int COLUMNS_DEF = 8;
	localparam int ROWS_DEF    = 8;
	localparam int MAX_OUT     = 64;
	localparam int K_W         = $clog2(MAX_OUT + 1);
	localparam int MIN_LEN     = 6;

	// Register reset values
	localparam logic [15:0] SPAWN_LIMIT_RST = 16'd600;
	localparam logic [15:0] END_GRACE_RST   = 16'd100;
	localparam logic [7:0]  HEAD_LEVEL_RST  = 8'd120;
	localparam logic [7:0]  TRAIL_TOP_RST   = 8'd80;

	// Register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAWN_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_GRACE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_LEVEL  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIL_TOP   = 2'd3;

	// One generated pixel
	typedef struct packed {
		logic [2:0] col;
		logic [2:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// Values that hold for every item of one tick
	typedef struct packed {
		logic [3:0] beams_active;
		logic       finished;
	} tick_info_t;

	// One result item as presented on the output channel
	typedef struct packed {
		logic       pixel_valid;
		pix_t       pix;
		logic [3:0] beams_active;
		logic       finished;
		logic       last;
	} out_item_t;

	// Output stage status seen by the sequencer
	typedef struct packed {
		logic can_take;
		logic out_free;
	} out_stat_t;

endpackage

[design/fba_div.sv]
module fba_div (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [4:0] divisor,
	output logic       busy,
	output logic [7:0] quotient
);

	logic [7:0] dvd_q;
	logic [4:0] dsr_q;
	logic [4:0] rem_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic [5:0] trial;
	logic       fits;

	// Restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[7]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Quotient bits shift in where the dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 5'(trial - {1'b0, dsr_q}) : trial[4:0];
			dvd_q <= {dvd_q[6:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

[design/fba_out.sv]
module fba_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  fba_pkg::pix_t          pix,
	input  logic                   flush,
	input  fba_pkg::tick_info_t    tick,
	input  logic                   out_ready,
	output logic                   out_valid,
	output fba_pkg::out_item_t     item,
	output fba_pkg::out_stat_t     stat
);

	logic               out_valid_q;
	fba_pkg::out_item_t item_q;
	logic               pend_q;
	fba_pkg::pix_t      pend_pix_q;
	logic               out_free;

	assign out_free      = !out_valid_q || out_ready;
	assign stat.out_free = out_free;
	assign stat.can_take = !pend_q || out_free;

	// Handshake and pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (flush) begin
			out_valid_q <= 1'b1;
			pend_q      <= 1'b0;
		end else if (push) begin
			pend_q <= 1'b1;
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// One pixel is held back so that the final item of a tick can carry last
	always_ff @(posedge clk) begin
		if (flush) begin
			item_q.pixel_valid  <= pend_q;
			item_q.pix          <= pend_q ? pend_pix_q : '0;
			item_q.beams_active <= tick.beams_active;
			item_q.finished     <= tick.finished;
			item_q.last         <= 1'b1;
		end else if (push) begin
			pend_pix_q <= pix;
			if (pend_q) begin
				item_q.pixel_valid  <= 1'b1;
				item_q.pix          <= pend_pix_q;
				item_q.beams_active <= tick.beams_active;
				item_q.finished     <= 1'b0;
				item_q.last         <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign item      = item_q;

endmodule

[design/falling_beam_led_animator_core.sv]
// Falling-beam animator: one tick item in, a burst of pixel items out.
// Input channel (in_valid/in_ready) takes one tick item carrying brightness
// and the pre-drawn spawn choices; in_ready is high only while the block is
// between ticks. Output channel (out_valid/out_ready) gives one item per lit
// pixel, column by column, head first then trail; a tick with nothing lit
// gives a single empty-frame item. last marks the final item of the tick,
// and finished rides on that item only. The cfg_we/cfg_index/cfg_data port
// writes one of the four registers; the user must do so between ticks, which
// the block itself does not enforce. The quotient unit works out each active
// beam's fade step, and the sequencer walks trail pixels one a cycle, while
// the output stage can take them, through the shared 8x8 level multiplier.
// The next tick is taken as soon as the final item has been loaded into the
// output register.
// Reset clears the registers to their defaults, idles every column and
// zeroes the tick counter. A stalled receiver holds the current item; one
// further pixel waits in a pending register and the walk pauses until the
// output register frees up.
module falling_beam_led_animator_core #(
	parameter int COLUMNS = fba_pkg::COLUMNS_DEF,
	parameter int ROWS    = fba_pkg::ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     brightness,
	input  logic                           spawn_try,
	input  logic [2:0]                     spawn_col,
	input  logic [3:0]                     spawn_extra,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           pixel_valid,
	output logic [2:0]                     pixel_col,
	output logic [2:0]                     pixel_row,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [3:0]                     beams_active,
	output logic                           finished,
	output logic                           last
);

	localparam int CI_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CNT_W = $clog2(COLUMNS + 1);
	localparam int KW    = fba_pkg::K_W;

	typedef enum logic [2:0] {
		S_IDLE, S_HEAD, S_COL, S_HPIX, S_DIV, S_TRAIL, S_ADV, S_FLUSH
	} state_t;

	state_t state_q;

	// Registers
	logic [15:0] spawn_limit_q;
	logic [15:0] end_grace_q;
	logic [7:0]  head_level_q;
	logic [7:0]  trail_top_q;

	// Beam state
	logic [COLUMNS-1:0] active_q;
	logic [5:0]         pos_mem [COLUMNS];
	logic [4:0]         len_mem [COLUMNS];
	logic [15:0]        tick_q;

	// Per-tick working registers
	logic [7:0]      bright_q;
	logic [7:0]      head_q;
	logic [CNT_W-1:0] cnt_q;
	logic            fin_q;
	logic [CI_W-1:0] col_q;
	logic [5:0]      pos_q;
	logic [4:0]      len_q;
	logic [4:0]      i_q;
	logic [7:0]      fac_q;
	logic [7:0]      level_q;
	logic [KW-1:0]   k_q;

	logic              in_acc;
	logic [15:0]       tc_next;
	logic [CI_W-1:0]   sp_idx;
	logic              do_spawn;
	logic [CNT_W-1:0]  cnt_sum;
	logic [7:0]        mul_a;
	logic [15:0]       prod;
	logic              room;
	logic              head_want;
	logic              trail_want;
	logic [5:0]        trail_row;
	logic [6:0]        pos_inc;
	logic              last_col;
	logic              div_start;
	logic              div_busy;
	logic [7:0]        div_quot;
	logic              push;
	logic              flush;
	fba_pkg::pix_t     pix;
	fba_pkg::tick_info_t tick;
	fba_pkg::out_item_t  item;
	fba_pkg::out_stat_t  stat;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Tick counter saturates; spawn check uses the incremented value
	assign tc_next  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign sp_idx   = CI_W'(spawn_col);
	assign do_spawn = spawn_try && ({2'b00, spawn_col} < 5'(COLUMNS)) &&
		!active_q[sp_idx] && (tc_next < spawn_limit_q);

	// Active beam count
	always_comb begin
		cnt_sum = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			cnt_sum = cnt_sum + CNT_W'(active_q[c]);
		end
	end

	// Shared level multiplier: head level once per tick, then trail levels
	assign mul_a = (state_q == S_HEAD) ? head_level_q : level_q;
	assign prod  = mul_a * bright_q;

	assign room       = k_q < KW'(fba_pkg::MAX_OUT);
	assign head_want  = (pos_q < 6'(ROWS)) && room;
	assign trail_row  = pos_q - 6'(i_q);
	assign trail_want = ({1'b0, i_q} <= pos_q) && (trail_row < 6'(ROWS)) && room;
	assign pos_inc    = 7'(pos_q) + 7'd1;
	assign last_col   = (col_q == CI_W'(COLUMNS - 1));
	assign div_start  = (state_q == S_COL) && active_q[col_q];

	// Pixel offered to the output stage
	always_comb begin
		push      = 1'b0;
		pix.col   = 3'(col_q);
		pix.row   = 3'(pos_q);
		pix.red   = head_q;
		pix.green = head_q;
		pix.blue  = head_q;
		if (state_q == S_HPIX) begin
			push = head_want && stat.can_take;
		end else if (state_q == S_TRAIL) begin
			push      = (i_q < len_q) && trail_want && stat.can_take;
			pix.row   = 3'(trail_row);
			pix.red   = '0;
			pix.green = prod[15:8];
			pix.blue  = '0;
		end
	end

	assign flush = (state_q == S_FLUSH) && stat.out_free;
	assign tick.beams_active = 4'(cnt_q);
	assign tick.finished     = fin_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spawn_limit_q <= fba_pkg::SPAWN_LIMIT_RST;
			end_grace_q   <= fba_pkg::END_GRACE_RST;
			head_level_q  <= fba_pkg::HEAD_LEVEL_RST;
			trail_top_q   <= fba_pkg::TRAIL_TOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fba_pkg::REG_SPAWN_LIMIT: spawn_limit_q <= cfg_data;
				fba_pkg::REG_END_GRACE:   end_grace_q   <= cfg_data;
				fba_pkg::REG_HEAD_LEVEL:  head_level_q  <= cfg_data[7:0];
				fba_pkg::REG_TRAIL_TOP:   trail_top_q   <= cfg_data[7:0];
			endcase
		end
	end

	// Beam position and length store
	always_ff @(posedge clk) begin
		if (in_acc && do_spawn) begin
			pos_mem[sp_idx] <= 6'd1;
			len_mem[sp_idx] <= 5'(fba_pkg::MIN_LEN) + 5'(spawn_extra);
		end else if (state_q == S_ADV) begin
			pos_mem[col_q] <= (pos_inc > 7'(len_q) + 7'(ROWS)) ? 6'd0 : pos_inc[5:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= '0;
			tick_q   <= '0;
			bright_q <= '0;
			head_q   <= '0;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			col_q    <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			i_q      <= '0;
			fac_q    <= '0;
			level_q  <= '0;
			k_q      <= '0;
		end else begin
			if (push) begin
				k_q <= k_q + KW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						tick_q   <= tc_next;
						bright_q <= brightness;
						k_q      <= '0;
						if (do_spawn) begin
							active_q[sp_idx] <= 1'b1;
						end
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					head_q  <= prod[15:8];
					cnt_q   <= cnt_sum;
					fin_q   <= ({1'b0, tick_q} > ({1'b0, spawn_limit_q} + {1'b0, end_grace_q}))
						&& (cnt_sum == '0);
					col_q   <= '0;
					state_q <= S_COL;
				end
				S_COL: begin
					if (active_q[col_q]) begin
						pos_q   <= pos_mem[col_q];
						len_q   <= len_mem[col_q];
						state_q <= S_HPIX;
					end else if (last_col) begin
						state_q <= S_FLUSH;
					end else begin
						col_q <= col_q + CI_W'(1);
					end
				end
				S_HPIX: begin
					if (!head_want || stat.can_take) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						fac_q   <= div_quot;
						level_q <= trail_top_q - div_quot;
						i_q     <= 5'd1;
						state_q <= S_TRAIL;
					end
				end
				S_TRAIL: begin
					if (i_q >= len_q) begin
						state_q <= S_ADV;
					end else if (!trail_want || stat.can_take) begin
						i_q     <= i_q + 5'd1;
						level_q <= level_q - fac_q;
					end
				end
				S_ADV: begin
					if (pos_inc > 7'(len_q) + 7'(ROWS)) begin
						active_q[col_q] <= 1'b0;
					end
					if (last_col) begin
						state_q <= S_FLUSH;
					end else begin
						col_q   <= col_q + CI_W'(1);
						state_q <= S_COL;
					end
				end
				S_FLUSH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	fba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (trail_top_q),
		.divisor  (len_mem[col_q]),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	fba_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pix       (pix),
		.flush     (flush),
		.tick      (tick),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.item      (item),
		.stat      (stat)
	);

	assign pixel_valid  = item.pixel_valid;
	assign pixel_col    = item.pix.col;
	assign pixel_row    = item.pix.row;
	assign red          = item.pix.red;
	assign green        = item.pix.green;
	assign blue         = item.pix.blue;
	assign beams_active = item.beams_active;
	assign finished     = item.finished;
	assign last         = item.last;

endmodule

[verif/falling_beam_led_animator_core_test.sv]
module falling_beam_led_animator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS = fba_pkg::COLUMNS_DEF;
	localparam int ROWS    = fba_pkg::ROWS_DEF;
	localparam int DRAIN_CYCLES = 300;

	// One tick item as driven on the input channel
	typedef struct packed {
		logic [7:0] brightness;
		logic       spawn_try;
		logic [2:0] spawn_col;
		logic [3:0] spawn_extra;
	} tick_t;

	// Directed row: stimulus, plus a typed-in empty frame where obvious
	typedef struct packed {
		tick_t      stim;
		logic       typed;
		logic [3:0] beams;
	} row_t;

	localparam int N_DIRECTED = 22;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [fba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  brightness = '0;
	logic        spawn_try = 1'b0;
	logic [2:0]  spawn_col = '0;
	logic [3:0]  spawn_extra = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        pixel_valid;
	logic [2:0]  pixel_col;
	logic [2:0]  pixel_row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [3:0]  beams_active;
	logic        finished;
	logic        last;

	falling_beam_led_animator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.brightness   (brightness),
		.spawn_try    (spawn_try),
		.spawn_col    (spawn_col),
		.spawn_extra  (spawn_extra),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_valid  (pixel_valid),
		.pixel_col    (pixel_col),
		.pixel_row    (pixel_row),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.beams_active (beams_active),
		.finished     (finished),
		.last         (last)
	);

	// Directed ticks: min and max lengths, busy columns, brightness extremes,
	// a respawn after retirement; first row is the empty frame after reset
	row_t directed [N_DIRECTED] = '{
		'{'{8'd0,   1'b0, 3'd0, 4'd0},  1'b1, 4'd0},
		'{'{8'd255, 1'b1, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b1, 3'd0, 4'd15}, 1'b0, 4'd0},
		'{'{8'd128, 1'b1, 3'd7, 4'd15}, 1'b0, 4'd0},
		'{'{8'd1,   1'b1, 3'd5, 4'd13}, 1'b0, 4'd0},
		'{'{8'd170, 1'b1, 3'd2, 4'd5},  1'b0, 4'd0},
		'{'{8'd85,  1'b1, 3'd1, 4'd10}, 1'b0, 4'd0},
		'{'{8'd255, 1'b1, 3'd3, 4'd7},  1'b0, 4'd0},
		'{'{8'd255, 1'b1, 3'd4, 4'd1},  1'b0, 4'd0},
		'{'{8'd0,   1'b1, 3'd6, 4'd14}, 1'b0, 4'd0},
		'{'{8'd200, 1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b0, 3'd7, 4'd15}, 1'b0, 4'd0},
		'{'{8'd64,  1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd127, 1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b1, 3'd0, 4'd3},  1'b0, 4'd0},
		'{'{8'd255, 1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b1, 3'd0, 4'd15}, 1'b0, 4'd0},
		'{'{8'd33,  1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd240, 1'b0, 3'd0, 4'd0},  1'b0, 4'd0},
		'{'{8'd255, 1'b1, 3'd7, 4'd0},  1'b0, 4'd0}
	};

	// Animation state and registers as the block should hold them
	logic [5:0]  col_pos [COLUMNS];
	logic [4:0]  col_len [COLUMNS];
	logic [15:0] model_ticks;
	logic [15:0] spawn_limit;
	logic [15:0] end_grace;
	logic [7:0]  head_lvl;
	logic [7:0]  trail_lvl;

	fba_pkg::out_item_t expected_pixels [$];
	int        errors = 0;
	int        ticks_sent = 0;
	int        send_gap_pct = 7;
	int        recv_stall_pct = 73;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Work out the pixels of one tick and advance the beams
	function automatic void animate_tick(input tick_t t, input bit discard);
		fba_pkg::out_item_t burst [$];
		fba_pkg::out_item_t px;
		int unsigned head;
		int unsigned fade;
		int unsigned pos;
		int unsigned len;
		int unsigned active;
		bit          done;
		active = 0;
		if (model_ticks != 16'hFFFF)
			model_ticks++;
		if (t.spawn_try && col_pos[t.spawn_col] == 6'd0 && model_ticks < spawn_limit) begin
			col_pos[t.spawn_col] = 6'd1;
			col_len[t.spawn_col] = 5'(fba_pkg::MIN_LEN + 32'(t.spawn_extra));
		end
		head = (32'(head_lvl) * 32'(t.brightness)) >> 8;
		for (int c = 0; c < COLUMNS; c++) begin
			pos = 32'(col_pos[c]);
			len = 32'(col_len[c]);
			if (pos == 0)
				continue;
			active++;
			// head only while on screen
			if (pos < ROWS && burst.size() < fba_pkg::MAX_OUT) begin
				px = '0;
				px.pixel_valid = 1'b1;
				px.pix.col = 3'(c);
				px.pix.row = 3'(pos);
				px.pix.red = 8'(head);
				px.pix.green = 8'(head);
				px.pix.blue = 8'(head);
				burst.push_back(px);
			end
			// trail, nearest to the head first
			fade = (len != 0) ? 32'(trail_lvl) / len : 0;
			for (int unsigned i = 1; i < len; i++) begin
				if (i <= pos && pos - i < ROWS && burst.size() < fba_pkg::MAX_OUT) begin
					px = '0;
					px.pixel_valid = 1'b1;
					px.pix.col = 3'(c);
					px.pix.row = 3'(pos - i);
					px.pix.green = 8'(((32'(trail_lvl) - i * fade) * 32'(t.brightness)) >> 8);
					burst.push_back(px);
				end
			end
			pos++;
			if (pos > len + ROWS)
				pos = 0;
			col_pos[c] = 6'(pos);
		end
		if (burst.size() == 0)
			burst.push_back('0);
		done = (32'(model_ticks) > 32'(spawn_limit) + 32'(end_grace)) && active == 0;
		foreach (burst[j])
			burst[j].beams_active = 4'(active);
		burst[burst.size() - 1].finished = done;
		burst[burst.size() - 1].last = 1'b1;
		if (!discard)
			foreach (burst[j])
				expected_pixels.push_back(burst[j]);
	endfunction

	function automatic tick_t random_tick(input int try_pct);
		tick_t t;
		case ($urandom_range(7))
			0: t.brightness = 8'd0;
			1: t.brightness = 8'd255;
			default: t.brightness = 8'($urandom_range(255));
		endcase
		t.spawn_try = ($urandom_range(99) < try_pct);
		t.spawn_col = 3'($urandom_range(COLUMNS - 1));
		t.spawn_extra = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 14))
			: 4'($urandom_range(13));
		return t;
	endfunction

	// Offer one tick item, predict its pixels once taken
	task automatic send_tick(input tick_t t, input bit typed, input logic [3:0] beams);
		fba_pkg::out_item_t px;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		brightness <= t.brightness;
		spawn_try <= t.spawn_try;
		spawn_col <= t.spawn_col;
		spawn_extra <= t.spawn_extra;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		animate_tick(t, typed);
		if (typed) begin
			px = '0;
			px.beams_active = beams;
			px.last = 1'b1;
			expected_pixels.push_back(px);
		end
		ticks_sent++;
		// idling: sender rarely and receiver often, then swapped, then none
		if (ticks_sent < 110) begin
			send_gap_pct = 7;
			recv_stall_pct = 73;
		end else if (ticks_sent < 220) begin
			send_gap_pct = 73;
			recv_stall_pct = 7;
		end else begin
			send_gap_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	// Hold off the sender until every pixel has come out
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fba_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			fba_pkg::REG_SPAWN_LIMIT: spawn_limit = data;
			fba_pkg::REG_END_GRACE:   end_grace = data;
			fba_pkg::REG_HEAD_LEVEL:  head_lvl = data[7:0];
			fba_pkg::REG_TRAIL_TOP:   trail_lvl = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] limit, input logic [15:0] grace,
			input logic [7:0] headl, input logic [7:0] trail);
		settle();
		write_reg(fba_pkg::REG_SPAWN_LIMIT, limit);
		write_reg(fba_pkg::REG_END_GRACE, grace);
		write_reg(fba_pkg::REG_HEAD_LEVEL, {8'd0, headl});
		write_reg(fba_pkg::REG_TRAIL_TOP, {8'd0, trail});
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int n, input int try_pct);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(29) == 0)
				settle();
			send_tick(random_tick(try_pct), 1'b0, 4'd0);
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
			errors++;
		end
	endtask

	// Output side: check each pixel item taken, stall at random
	always @(posedge clk) begin : pixel_check
		fba_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected item col %0d row %0d, expected none", $time,
					pixel_col, pixel_row);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				compare_field("pixel_valid", want.pixel_valid, pixel_valid);
				compare_field("pixel_col", want.pix.col, pixel_col);
				compare_field("pixel_row", want.pix.row, pixel_row);
				compare_field("red", want.pix.red, red);
				compare_field("green", want.pix.green, green);
				compare_field("blue", want.pix.blue, blue);
				compare_field("beams_active", want.beams_active, beams_active);
				compare_field("finished", want.finished, finished);
				compare_field("last", want.last, last);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		// state after reset
		foreach (col_pos[c]) begin
			col_pos[c] = '0;
			col_len[c] = '0;
		end
		model_ticks = '0;
		spawn_limit = fba_pkg::SPAWN_LIMIT_RST;
		end_grace = fba_pkg::END_GRACE_RST;
		head_lvl = fba_pkg::HEAD_LEVEL_RST;
		trail_lvl = fba_pkg::TRAIL_TOP_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r])
			send_tick(directed[r].stim, directed[r].typed, directed[r].beams);

		// top extremes: spawning never stops, full levels
		set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		run_random(90, 50);
		// bottom extremes: no spawns, beams drain and finished rises
		set_config(16'h0000, 16'h0000, 8'h00, 8'h00);
		run_random(50, 40);
		// spawn window closes part way, short grace
		set_config(model_ticks + 16'd30, 16'd10, 8'($urandom_range(255)),
			8'($urandom_range(255)));
		run_random(100, 33);
		set_config(model_ticks + 16'd60, 16'd0, 8'($urandom_range(255)),
			8'($urandom_range(255, 1)));
		run_random(70, 70);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
design/fba_pkg.sv
design/fba_div.sv
design/fba_out.sv
design/falling_beam_led_animator_core.sv
verif/falling_beam_led_animator_core_test.sv
